@@ rtl/pcc_pkg.sv @@
// Shared types and codes for the polygon convexity classifier.
// Used by pcc_cell, pcc_geom and the top level; depends on nothing.
`default_nettype none
package pcc_pkg;

  // Default sizes
  localparam int DEF_MAX_VERTICES = 32;
  localparam int DEF_COORD_BITS   = 24;

  // Register interface
  localparam int TOL_BITS  = 51;
  localparam int REG_BITS  = 2;
  localparam logic [REG_BITS-1:0] REG_TOL    = 2'd0;
  localparam logic [REG_BITS-1:0] REG_REJECT = 2'd1;
  localparam logic [REG_BITS-1:0] REG_SPLIT  = 2'd2;

  // Result codes
  localparam logic       KIND_INDEX = 1'b0;
  localparam logic       KIND_FINAL = 1'b1;
  localparam logic [1:0] CLS_CONVEX = 2'd0;
  localparam logic [1:0] CLS_SINGLE = 2'd1;
  localparam logic [1:0] CLS_CONCAVE = 2'd2;
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_SPLIT    = 2'd1;
  localparam logic [1:0] ST_COLLIN   = 2'd2;
  localparam logic [1:0] ST_COUNT    = 2'd3;

  // Projection planes: X drops x (uses y,z), Y uses z,x, Z uses x,y
  localparam logic [1:0] PL_X = 2'd0;
  localparam logic [1:0] PL_Y = 2'd1;
  localparam logic [1:0] PL_Z = 2'd2;

  // Per-cell control
  typedef struct packed {
    logic load;
    logic shift;
    logic wrap;
  } cell_ctrl_t;

endpackage
`default_nettype wire

@@ rtl/polygon_convexity_classifier.sv @@
// Polygon convexity classifier: vertices load one per cycle into a ring of cells.
// After the final vertex, three passes turn the ring one vertex per step:
// Newell normal plus collinear check, winding, then turn tests with index output.
// Pass three and the final result wait on any output stall; the next polygon
// is taken once the final result is loaded.
// Reset (synchronous, rst high) sets control, counts and config registers to defaults.
`default_nettype none
module polygon_convexity_classifier #(
  parameter int MAX_VERTICES = pcc_pkg::DEF_MAX_VERTICES,
  parameter int COORD_BITS   = pcc_pkg::DEF_COORD_BITS
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // s_tdata: coord_x, coord_y, coord_z, zero fill
  input  wire logic [((3*COORD_BITS+7)/8)*8-1:0]    s_tdata,
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  input  wire logic                                 s_tlast,
  // m_tdata: vertex_index[4:0], shape_class[6:5], clockwise[7], status[9:8], zero fill
  output logic [15:0]                               m_tdata,
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  output logic                                      m_tlast,
  // m_tuser: result_kind
  output logic                                      m_tuser,
  input  wire logic                                 cfg_we,
  input  wire logic [pcc_pkg::REG_BITS-1:0]         cfg_addr,
  input  wire logic [pcc_pkg::TOL_BITS-1:0]         cfg_wdata
);
  import pcc_pkg::*;

  localparam int W    = COORD_BITS;
  localparam int VW   = 3 * W;
  localparam int DW   = W + 1;
  localparam int PW   = 2 * DW;
  localparam int CW   = PW + 1;
  localparam int AW   = PW + $clog2(MAX_VERTICES) + 1;
  localparam int TW   = ((CW > TOL_BITS) ? CW : TOL_BITS) + 1;
  localparam int CNTW = $clog2(MAX_VERTICES + 1);

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_P1A   = 4'd2;
  localparam logic [3:0] S_P1B   = 4'd3;
  localparam logic [3:0] S_SEL   = 4'd4;
  localparam logic [3:0] S_P2A   = 4'd5;
  localparam logic [3:0] S_P2B   = 4'd6;
  localparam logic [3:0] S_P3A   = 4'd7;
  localparam logic [3:0] S_P3B   = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;

  logic [3:0]           state;
  logic [CNTW-1:0]      count;
  logic [CNTW-1:0]      step;
  logic                 ovf;
  logic [TOL_BITS-1:0]  tol;
  logic                 reject;
  logic                 split;
  logic [VW-1:0]        last_v;
  logic [VW-1:0]        prev_v;
  logic [VW-1:0]        cells [MAX_VERTICES];
  cell_ctrl_t           ctrl [MAX_VERTICES];
  logic signed [AW-1:0] acc_n [3];
  logic signed [AW-1:0] wind;
  logic                 coll_flag;
  logic [1:0]           plane;
  logic [1:0]           status;
  logic [1:0]           left_cnt;
  logic [1:0]           right_cnt;

  logic signed [PW-1:0] nprod [3];
  logic signed [PW-1:0] cprod [6];
  logic signed [PW-1:0] wprod;
  logic signed [PW-1:0] tprod [2];

  logic                 in_acc;
  logic                 shift;
  logic                 last_step;
  logic                 obuf_free;
  logic                 out_load;
  logic [VW-1:0]        in_v;
  logic [TW-1:0]        tol_x;
  logic [2:0]           cbelow;
  logic                 tcoll;
  logic                 tneg;
  logic                 cw;
  logic                 isleft;
  logic                 counted;
  logic                 emit;
  logic [AW-1:0]        ax;
  logic [AW-1:0]        ay;
  logic [AW-1:0]        az;
  logic [1:0]           plane_sel;
  logic [1:0]           cls;

  function automatic logic [TW-1:0] mag(input logic signed [PW-1:0] a,
                                        input logic signed [PW-1:0] b);
    logic signed [CW-1:0] d;
    logic        [CW-1:0] m;
    d = CW'(a) - CW'(b);
    m = d[CW-1] ? CW'(-d) : CW'(d);
    mag = TW'(m);
  endfunction

  function automatic logic [AW-1:0] aabs(input logic signed [AW-1:0] a);
    aabs = a[AW-1] ? AW'(-a) : AW'(a);
  endfunction

  assign in_acc    = s_tvalid && s_tready;
  assign s_tready  = (state == S_LOAD);
  assign in_v      = s_tdata[VW-1:0];
  assign obuf_free = !m_tvalid || m_tready;
  assign last_step = (step == count - CNTW'(1));
  assign tol_x     = TW'(tol);

  // Ring of vertex cells, turning one place per pass step
  for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
    assign ctrl[k] = cell_ctrl_t'{
      load:  in_acc && (count < CNTW'(MAX_VERTICES)) && (count == CNTW'(k)),
      shift: shift,
      wrap:  (CNTW'(k) == count - CNTW'(1))
    };
    if (k == MAX_VERTICES - 1) begin : g_end
      pcc_cell #(.W(W)) u_cell (
        .clk(clk), .ctrl(ctrl[k]), .load_data(in_v),
        .next_data(cells[0]), .head_data(cells[0]), .data(cells[k])
      );
    end else begin : g_mid
      pcc_cell #(.W(W)) u_cell (
        .clk(clk), .ctrl(ctrl[k]), .load_data(in_v),
        .next_data(cells[k+1]), .head_data(cells[0]), .data(cells[k])
      );
    end
  end

  pcc_geom #(.W(W)) u_geom (
    .clk(clk),
    .en(state inside {S_P1A, S_P2A, S_P3A}),
    .plane(plane),
    .prev_v(prev_v),
    .cur_v(cells[0]),
    .next_v(cells[1 % MAX_VERTICES]),
    .nprod(nprod),
    .cprod(cprod),
    .wprod(wprod),
    .tprod(tprod)
  );

  // Collinearity and turn decisions from the registered products
  always_comb begin
    cbelow[0] = mag(cprod[0], cprod[1]) < tol_x;
    cbelow[1] = mag(cprod[2], cprod[3]) < tol_x;
    cbelow[2] = mag(cprod[4], cprod[5]) < tol_x;
    tcoll     = mag(tprod[0], tprod[1]) < tol_x;
    tneg      = (tprod[0] < tprod[1]);
    cw        = !wind[AW-1] && (wind != '0);
    isleft    = tcoll ? cw : tneg;
    counted   = !(tcoll && reject);
    emit      = counted && (isleft == cw);
  end

  // Projection plane with its tie rules
  always_comb begin
    ax = aabs(acc_n[0]);
    ay = aabs(acc_n[1]);
    az = aabs(acc_n[2]);
    if (ax > ay && ax > az)      plane_sel = PL_X;
    else if (ay > az && ay > ax) plane_sel = PL_Y;
    else if (ax == ay)           plane_sel = (ax > az) ? PL_X : PL_Z;
    else if (ay == az)           plane_sel = (ay > ax) ? PL_Y : PL_X;
    else if (ax == az)           plane_sel = (ax > ay) ? PL_Z : PL_Y;
    else                         plane_sel = PL_Z;
  end

  // Shape class from the saturated turn counts
  always_comb begin
    if (left_cnt == 2'd0 || right_cnt == 2'd0)      cls = CLS_CONVEX;
    else if (left_cnt == 2'd1 || right_cnt == 2'd1) cls = CLS_SINGLE;
    else                                            cls = CLS_CONCAVE;
  end

  assign shift = (state inside {S_P1B, S_P2B}) ||
                 ((state == S_P3B) && (!emit || obuf_free));

  assign out_load = ((state == S_P3B) && shift && emit) ||
                    ((state == S_FIN) && obuf_free);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tol    <= TOL_BITS'(1);
      reject <= 1'b0;
      split  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_TOL:    tol    <= cfg_wdata;
        REG_REJECT: reject <= cfg_wdata[0];
        REG_SPLIT:  split  <= cfg_wdata[0];
        default:    ;
      endcase
    end
  end

  // Output register valid: set on a loaded item, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Sequencer: load, up to three ring passes, final result
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      count     <= '0;
      ovf       <= 1'b0;
      step      <= '0;
      coll_flag <= 1'b0;
      status    <= ST_OK;
      left_cnt  <= 2'd0;
      right_cnt <= 2'd0;
      plane     <= PL_Z;
    end else begin
      case (state)
        S_LOAD: begin
          if (in_acc) begin
            if (count < CNTW'(MAX_VERTICES)) begin
              count  <= count + CNTW'(1);
              last_v <= in_v;
            end else begin
              ovf <= 1'b1;
            end
            if (s_tlast) state <= S_START;
          end
        end
        S_START: begin
          step      <= '0;
          prev_v    <= last_v;
          coll_flag <= 1'b0;
          acc_n[0]  <= '0;
          acc_n[1]  <= '0;
          acc_n[2]  <= '0;
          if (ovf || count < CNTW'(3)) begin
            status <= ST_COUNT;
            state  <= S_FIN;
          end else if (split && count < CNTW'(4)) begin
            status <= ST_SPLIT;
            state  <= S_FIN;
          end else begin
            status <= ST_OK;
            state  <= S_P1A;
          end
        end
        S_P1A: state <= S_P1B;
        S_P1B: begin
          for (int a = 0; a < 3; a++) acc_n[a] <= acc_n[a] + AW'(nprod[a]);
          if (reject && (&cbelow)) coll_flag <= 1'b1;
          prev_v <= cells[0];
          step   <= step + CNTW'(1);
          state  <= last_step ? S_SEL : S_P1A;
        end
        S_SEL: begin
          step      <= '0;
          wind      <= '0;
          left_cnt  <= 2'd0;
          right_cnt <= 2'd0;
          plane     <= plane_sel;
          if (coll_flag) begin
            status <= ST_COLLIN;
            state  <= S_FIN;
          end else begin
            state <= S_P2A;
          end
        end
        S_P2A: state <= S_P2B;
        S_P2B: begin
          wind   <= wind + AW'(wprod);
          prev_v <= cells[0];
          step   <= last_step ? '0 : step + CNTW'(1);
          state  <= last_step ? S_P3A : S_P2A;
        end
        S_P3A: state <= S_P3B;
        S_P3B: begin
          if (shift) begin
            if (counted) begin
              if (isleft) left_cnt  <= (left_cnt == 2'd2) ? 2'd2 : left_cnt + 2'd1;
              else        right_cnt <= (right_cnt == 2'd2) ? 2'd2 : right_cnt + 2'd1;
            end
            if (emit) begin
              m_tuser  <= KIND_INDEX;
              m_tlast  <= 1'b0;
              m_tdata  <= {6'd0, ST_OK, 1'b0, CLS_CONVEX, 5'(step)};
            end
            prev_v <= cells[0];
            step   <= step + CNTW'(1);
            state  <= last_step ? S_FIN : S_P3A;
          end
        end
        S_FIN: begin
          if (obuf_free) begin
            m_tuser  <= KIND_FINAL;
            m_tlast  <= 1'b1;
            if (status == ST_OK) m_tdata <= {6'd0, ST_OK, cw, cls, 5'd0};
            else                 m_tdata <= {6'd0, status, 1'b0, CLS_CONVEX, 5'd0};
            count <= '0;
            ovf   <= 1'b0;
            state <= S_LOAD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  // The final vertex starts classification in the next cycle
  a_start: assert property (@(posedge clk) disable iff (rst)
    (in_acc && s_tlast) |=> (state == S_START))
    else $error("classification did not start after final vertex");

  // A concave vertex found with a free output register is presented next cycle
  a_emit: assert property (@(posedge clk) disable iff (rst)
    (state == S_P3B && emit && obuf_free) |=> (m_tvalid && !m_tuser))
    else $error("concave vertex index not presented");

  // Loading the final result empties the vertex store
  a_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && obuf_free) |=> (count == '0 && !ovf && m_tvalid && m_tlast))
    else $error("store not emptied with final result");

endmodule
`default_nettype wire

@@ rtl/pcc_cell.sv @@
// One vertex cell of the storage ring.
// Depends on pcc_pkg for the cell control struct.
`default_nettype none
module pcc_cell #(
  parameter int W = 24
) (
  input  wire logic                clk,
  input  wire pcc_pkg::cell_ctrl_t ctrl,
  input  wire logic [3*W-1:0]      load_data,
  input  wire logic [3*W-1:0]      next_data,
  input  wire logic [3*W-1:0]      head_data,
  output logic      [3*W-1:0]      data
);
  import pcc_pkg::*;

  // Load a new vertex, or take the neighbour's vertex as the ring turns
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      data <= load_data;
    end else if (ctrl.shift) begin
      data <= ctrl.wrap ? head_data : next_data;
    end
  end

endmodule
`default_nettype wire

@@ rtl/pcc_geom.sv @@
// Product unit: forms the Newell, collinearity, winding and turn products
// for one (prev, cur, next) vertex triple and registers them. Uses pcc_pkg.
`default_nettype none
module pcc_geom #(
  parameter int W = 24
) (
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire logic [1:0]              plane,
  input  wire logic [3*W-1:0]          prev_v,
  input  wire logic [3*W-1:0]          cur_v,
  input  wire logic [3*W-1:0]          next_v,
  output logic signed [2*(W+1)-1:0]    nprod [3],
  output logic signed [2*(W+1)-1:0]    cprod [6],
  output logic signed [2*(W+1)-1:0]    wprod,
  output logic signed [2*(W+1)-1:0]    tprod [2]
);
  import pcc_pkg::*;

  localparam int DW = W + 1;
  localparam int PW = 2 * DW;

  logic signed [W-1:0]  p [3];
  logic signed [W-1:0]  c [3];
  logic signed [W-1:0]  q [3];
  logic signed [DW-1:0] u [3];
  logic signed [DW-1:0] v [3];
  logic [1:0]           i1;
  logic [1:0]           i2;

  function automatic logic signed [DW-1:0] dif(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    dif = DW'(a) - DW'(b);
  endfunction

  function automatic logic signed [DW-1:0] sm(input logic signed [W-1:0] a,
                                              input logic signed [W-1:0] b);
    sm = DW'(a) + DW'(b);
  endfunction

  function automatic logic signed [PW-1:0] mul(input logic signed [DW-1:0] a,
                                               input logic signed [DW-1:0] b);
    mul = PW'(a) * PW'(b);
  endfunction

  // Split the packed vertices into axes
  for (genvar a = 0; a < 3; a++) begin : g_axis
    assign p[a] = prev_v[a*W +: W];
    assign c[a] = cur_v[a*W +: W];
    assign q[a] = next_v[a*W +: W];
    assign u[a] = dif(c[a], p[a]);
    assign v[a] = dif(q[a], p[a]);
  end

  // Axis pair of the projection plane
  always_comb begin
    case (plane)
      PL_X:    begin i1 = 2'd1; i2 = 2'd2; end
      PL_Y:    begin i1 = 2'd2; i2 = 2'd0; end
      default: begin i1 = 2'd0; i2 = 2'd1; end
    endcase
  end

  // Register all products of this triple
  always_ff @(posedge clk) begin
    if (en) begin
      nprod[0] <= mul(dif(c[1], q[1]), sm(c[2], q[2]));
      nprod[1] <= mul(dif(c[2], q[2]), sm(c[0], q[0]));
      nprod[2] <= mul(dif(c[0], q[0]), sm(c[1], q[1]));
      cprod[0] <= mul(u[1], v[2]);
      cprod[1] <= mul(u[2], v[1]);
      cprod[2] <= mul(u[0], v[2]);
      cprod[3] <= mul(u[2], v[0]);
      cprod[4] <= mul(u[1], v[0]);
      cprod[5] <= mul(u[0], v[1]);
      wprod    <= mul(dif(q[i1], c[i1]), sm(q[i2], c[i2]));
      tprod[0] <= mul(u[i2], v[i1]);
      tprod[1] <= mul(u[i1], v[i2]);
    end
  end

endmodule
`default_nettype wire

@@ tb/polygon_convexity_classifier_test.sv @@
// Self-checking testbench for the polygon convexity classifier.
// Holds its own predictor of the classifier in a scoreboard class; instantiates only
// the top level of the block and imports pcc_pkg.
`default_nettype none
module polygon_convexity_classifier_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pcc_pkg::*;

  localparam int NV = DEF_MAX_VERTICES;
  localparam int CB = DEF_COORD_BITS;

  typedef struct {
    logic       kind;
    logic [4:0] idx;
    logic [1:0] cls;
    logic       cw;
    logic [1:0] st;
    logic       last;
  } result_t;

  // Predicts the results of each polygon and checks them in order
  class convexity_scoreboard;
    longint  sx[NV], sy[NV], sz[NV];
    int      count;
    bit      overflow;
    longint  tol;
    bit      reject, split;
    result_t waiting[$];
    int      errors;

    function new();
      tol = 1;
    endfunction

    function void set_reg(logic [REG_BITS-1:0] addr, logic [TOL_BITS-1:0] data);
      case (addr)
        REG_TOL:    tol = longint'(data);
        REG_REJECT: reject = data[0];
        REG_SPLIT:  split = data[0];
        default: ;
      endcase
    endfunction

    function longint mag(longint a);
      return (a < 0) ? -a : a;
    endfunction

    function longint at(int i, int axis);
      return (axis == 0) ? sx[i] : (axis == 1) ? sy[i] : sz[i];
    endfunction

    function void add_result(logic kind, logic [4:0] idx, logic [1:0] cls, logic cw,
                             logic [1:0] st, logic last);
      result_t r;
      r.kind = kind; r.idx = idx; r.cls = cls; r.cw = cw; r.st = st; r.last = last;
      waiting.insert(waiting.size(), r);
    endfunction

    function void classify();
      int n, p, q, a1, a2, left, right;
      longint nx, ny, nz, ax, ay, az, wind, t1, t2, res, ux, uy, uz, wx, wy, wz;
      bit cw, isleft;
      logic [1:0] cls;
      n = count;
      nx = 0; ny = 0; nz = 0; wind = 0; left = 0; right = 0;
      if (overflow || n < 3) begin
        add_result(KIND_FINAL, 0, CLS_CONVEX, 0, ST_COUNT, 1);
        return;
      end
      if (split && n < 4) begin
        add_result(KIND_FINAL, 0, CLS_CONVEX, 0, ST_SPLIT, 1);
        return;
      end
      // reject mode: any degenerate 3D turn fails the polygon
      if (reject) begin
        for (int i = 0; i < n; i++) begin
          p = (i == 0) ? n - 1 : i - 1;
          q = (i + 1) % n;
          ux = sx[i] - sx[p]; uy = sy[i] - sy[p]; uz = sz[i] - sz[p];
          wx = sx[q] - sx[p]; wy = sy[q] - sy[p]; wz = sz[q] - sz[p];
          if (mag(uy * wz - uz * wy) < tol && mag(ux * wz - uz * wx) < tol &&
              mag(uy * wx - ux * wy) < tol) begin
            add_result(KIND_FINAL, 0, CLS_CONVEX, 0, ST_COLLIN, 1);
            return;
          end
        end
      end
      // Newell normal and projection plane
      for (int i = 0; i < n; i++) begin
        q = (i + 1) % n;
        nx += (sy[i] - sy[q]) * (sz[i] + sz[q]);
        ny += (sz[i] - sz[q]) * (sx[i] + sx[q]);
        nz += (sx[i] - sx[q]) * (sy[i] + sy[q]);
      end
      ax = mag(nx); ay = mag(ny); az = mag(nz);
      if (ax > ay && ax > az) begin a1 = 1; a2 = 2; end
      else if (ay > az && ay > ax) begin a1 = 2; a2 = 0; end
      else if (ax == ay) begin
        if (ax > az) begin a1 = 1; a2 = 2; end else begin a1 = 0; a2 = 1; end
      end else if (ay == az) begin
        if (ay > ax) begin a1 = 2; a2 = 0; end else begin a1 = 1; a2 = 2; end
      end else if (ax == az) begin
        if (ax > ay) begin a1 = 0; a2 = 1; end else begin a1 = 2; a2 = 0; end
      end else begin a1 = 0; a2 = 1; end
      // winding of the projection
      for (int i = 0; i < n; i++) begin
        q = (i + 1) % n;
        wind += (at(q, a1) - at(i, a1)) * (at(q, a2) + at(i, a2));
      end
      cw = wind > 0;
      // turn tests, concave indices in ascending order
      for (int i = 0; i < n; i++) begin
        p = (i == 0) ? n - 1 : i - 1;
        q = (i + 1) % n;
        t1 = at(i, a1) - at(p, a1);
        t2 = at(i, a2) - at(p, a2);
        res = t2 * (at(q, a1) - at(p, a1)) - t1 * (at(q, a2) - at(p, a2));
        if (mag(res) < tol) begin
          if (reject) continue;
          isleft = cw;
        end else begin
          isleft = res < 0;
        end
        if (isleft) left++; else right++;
        if (isleft == cw) add_result(KIND_INDEX, i[4:0], CLS_CONVEX, 0, ST_OK, 0);
      end
      if (left == 0 || right == 0) cls = CLS_CONVEX;
      else if (left == 1 || right == 1) cls = CLS_SINGLE;
      else cls = CLS_CONCAVE;
      add_result(KIND_FINAL, 0, cls, cw, ST_OK, 1);
    endfunction

    function void note_vertex(logic [CB-1:0] x, logic [CB-1:0] y, logic [CB-1:0] z,
                              logic fin);
      if (count < NV) begin
        sx[count] = longint'($signed(x));
        sy[count] = longint'($signed(y));
        sz[count] = longint'($signed(z));
        count++;
      end else begin
        overflow = 1;
      end
      if (fin) begin
        classify();
        count = 0;
        overflow = 0;
      end
    endfunction

    function void check_result(logic kind, logic [15:0] data, logic last);
      result_t e;
      if (waiting.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: kind %0d data %h last %0d", kind, data, last);
        return;
      end
      e = waiting.pop_front();
      if (kind !== e.kind || data[4:0] !== e.idx || data[6:5] !== e.cls ||
          data[7] !== e.cw || data[9:8] !== e.st || last !== e.last) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected kind %0d idx %0d cls %0d cw %0d st %0d last %0d, ",
                   "got kind %0d idx %0d cls %0d cw %0d st %0d last %0d",
                   e.kind, e.idx, e.cls, e.cw, e.st, e.last,
                   kind, data[4:0], data[6:5], data[7], data[9:8], last);
      end
    endfunction
  endclass

  logic                   clk, rst;
  logic [71:0]            s_tdata;
  logic                   s_tvalid, s_tlast, s_tready;
  logic [15:0]            m_tdata;
  logic                   m_tvalid, m_tready, m_tlast, m_tuser;
  logic                   cfg_we;
  logic [REG_BITS-1:0]    cfg_addr;
  logic [TOL_BITS-1:0]    cfg_wdata;

  convexity_scoreboard sb = new();
  bit calm, hold, pressure_go;
  int vx[$], vy[$], vz[$];
  int items_sent;

  polygon_convexity_classifier DUT (
    .clk(clk), .rst(rst),
    .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tlast(s_tlast),
    .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tlast(m_tlast),
    .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Receiver: check each accepted result, then pick ready for the next edge
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata, m_tlast);
    if (rst || hold) m_tready <= 1'b0;
    else m_tready <= calm || ($urandom_range(99) >= 27);
  end

  // Long receiver hold-off while the sender keeps offering items
  initial begin
    hold = 0;
    wait (pressure_go);
    @(posedge clk);
    hold <= 1'b1;
    repeat (400) @(posedge clk);
    hold <= 1'b0;
  end

  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

  function void add_vertex(int x, int y, int z);
    vx.insert(vx.size(), x); vy.insert(vy.size(), y); vz.insert(vz.size(), z);
  endfunction

  function int rcoord(int bits);
    return int'($urandom) >>> (32 - bits);
  endfunction

  // Send the queued polygon, last flag on its final vertex
  task automatic send_polygon();
    for (int i = 0; i < vx.size(); i++) begin
      while (!calm && $urandom_range(99) < 27) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
      s_tdata  <= {vz[i][CB-1:0], vy[i][CB-1:0], vx[i][CB-1:0]};
      s_tlast  <= (i == vx.size() - 1);
      s_tvalid <= 1'b1;
      do @(posedge clk); while (!s_tready);
      sb.note_vertex(vx[i][CB-1:0], vy[i][CB-1:0], vz[i][CB-1:0], i == vx.size() - 1);
      items_sent++;
    end
    vx.delete(); vy.delete(); vz.delete();
  endtask

  // Drain all results, let the block settle, then write the registers
  task automatic set_regs(longint t, bit rej, bit spl);
    s_tvalid <= 1'b0;
    while (sb.waiting.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    cfg_we <= 1'b1; cfg_addr <= REG_TOL; cfg_wdata <= t[TOL_BITS-1:0];
    @(posedge clk);
    sb.set_reg(REG_TOL, t[TOL_BITS-1:0]);
    cfg_addr <= REG_REJECT; cfg_wdata <= TOL_BITS'(rej);
    @(posedge clk);
    sb.set_reg(REG_REJECT, TOL_BITS'(rej));
    cfg_addr <= REG_SPLIT; cfg_wdata <= TOL_BITS'(spl);
    @(posedge clk);
    sb.set_reg(REG_SPLIT, TOL_BITS'(spl));
    cfg_we <= 1'b0;
  endtask

  task automatic rand_polygon(bit force_over);
    int n, mode, bits, rot, a, b, c, h, u[4], v[4];
    mode = force_over ? 9 : $urandom_range(99);
    if (mode < 8) begin
      // too few vertices
      n = $urandom_range(2, 1);
      for (int i = 0; i < n; i++) add_vertex(rcoord(24), rcoord(24), rcoord(24));
    end else if (mode < 12) begin
      // more vertices than the store holds
      n = $urandom_range(NV + 4, NV + 1);
      for (int i = 0; i < n; i++) add_vertex(rcoord(24), rcoord(24), rcoord(24));
    end else if (mode < 45) begin
      // convex parallelogram on a random axis plane, either winding
      a = $urandom_range(1 << 20, 1); b = $urandom_range(1 << 20, 1);
      c = rcoord(20); h = rcoord(24); rot = $urandom_range(2);
      u = '{0, a, a + c, c}; v = '{0, 0, b, b};
      for (int k = 0; k < 4; k++) begin
        int i;
        i = (mode & 1) ? 3 - k : k;
        if (rot == 0) add_vertex(u[i], v[i], h);
        else if (rot == 1) add_vertex(h, u[i], v[i]);
        else add_vertex(v[i], h, u[i]);
      end
    end else if (mode < 55) begin
      // points on a line with one off it
      n = $urandom_range(5, 3);
      a = rcoord(12); b = rcoord(12); c = rcoord(12);
      for (int i = 0; i < n - 1; i++) add_vertex(a * i, b * i, c * i);
      add_vertex(rcoord(16), rcoord(16), rcoord(16));
    end else begin
      // random points at a random scale
      n = $urandom_range(12, 3);
      bits = $urandom_range(24, 4);
      for (int i = 0; i < n; i++) add_vertex(rcoord(bits), rcoord(bits), rcoord(bits));
    end
    send_polygon();
  endtask

  task automatic rand_phase(int quota, bit with_over);
    int start;
    start = items_sent;
    if (with_over) rand_polygon(1);
    while (items_sent - start < quota) rand_polygon(0);
  endtask

  localparam int S = 65536;

  initial begin
    rst = 1'b1; s_tvalid = 1'b0; s_tlast = 1'b0; s_tdata = '0; m_tready = 1'b0;
    cfg_we = 1'b0; cfg_addr = REG_TOL; cfg_wdata = '0;
    calm = 0; pressure_go = 0; items_sent = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extreme coordinates, concave shape, collinear, too few points
    add_vertex(-8388608, -8388608, 8388607);
    add_vertex(8388607, -8388608, 0);
    add_vertex(0, 8388607, -8388608);
    send_polygon();
    add_vertex(0, 0, 0); add_vertex(4 * S, 0, 0); add_vertex(4 * S, 4 * S, 0);
    add_vertex(2 * S, S, 0); add_vertex(0, 4 * S, 0);
    send_polygon();
    add_vertex(0, 0, 0); add_vertex(2 * S, 0, 0); add_vertex(4 * S, 0, 0);
    send_polygon();
    add_vertex(S, S, S); add_vertex(-S, 0, S);
    send_polygon();

    // Directed: split check with three points, collinear in reject mode
    set_regs(1000, 1, 1);
    add_vertex(0, 0, 0); add_vertex(S, 0, 0); add_vertex(0, S, 0);
    send_polygon();
    add_vertex(0, 0, 0); add_vertex(2 * S, 0, 0); add_vertex(4 * S, 0, 0);
    add_vertex(4 * S, 4 * S, 0); add_vertex(0, 4 * S, 0);
    send_polygon();

    // Directed: plane ties, |nx| = |ny| and all components equal
    set_regs(0, 0, 0);
    add_vertex(0, 0, 0); add_vertex(S, -S, 0); add_vertex(0, 0, S);
    send_polygon();
    add_vertex(S, 0, 0); add_vertex(0, S, 0); add_vertex(0, 0, S);
    send_polygon();

    // Random phases across register settings
    set_regs(1, 0, 0);
    calm = 1;
    rand_phase(75, 1);
    calm = 0;
    set_regs(64'd1 << 50, 1, 0);
    pressure_go = 1;
    rand_phase(65, 0);
    set_regs(longint'($urandom_range(1 << 30)), 1, 1);
    rand_phase(95, 1);
    set_regs(0, 0, 1);
    rand_phase(90, 0);

    s_tvalid <= 1'b0;
    while (sb.waiting.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
